[rtl/uls_pkg.sv]
// Shared types and constants for the unimodal line search controller.
// No dependencies; used by uls_step and unimodal_line_search.
`default_nettype none

package uls_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned TOL_W = 31;
	localparam int unsigned OFS_W = 30;
	localparam int unsigned CFG_IDX_W = 2;

	// 1/phi in Q0.32.
	localparam logic [31:0] INV_PHI_Q32 = 32'd2654435769;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic OP_START = 1'b0;
	localparam logic OP_VALUE = 1'b1;

	localparam logic METHOD_DICHOTOMY = 1'b0;
	localparam logic METHOD_GOLDEN = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROBE_OFFSET = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'b0001,
		PH_LEFT_CMP  = 4'b0010,
		PH_RIGHT_CMP = 4'b0100,
		PH_LEFT_NEXT = 4'b1000
	} phase_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] left_end;
		logic signed [COORD_W-1:0] right_end;
		logic signed [COORD_W-1:0] inner_left;
		logic signed [COORD_W-1:0] inner_right;
		logic signed [COORD_W-1:0] value_left;
		logic signed [COORD_W-1:0] value_right;
		phase_t phase;
		logic [COUNT_W-1:0] reductions;
	} srch_state_t;

	typedef struct packed {
		logic op;
		logic signed [COORD_W-1:0] lower;
		logic signed [COORD_W-1:0] upper;
		logic signed [COORD_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] query_point;
		logic query_valid;
		logic done_res;
		logic signed [COORD_W-1:0] minimum_point;
		logic [COUNT_W-1:0] iteration_count;
		logic protocol_error;
	} result_t;

endpackage

`default_nettype wire

[rtl/uls_step.sv]
// Next-state and result logic for one item of the line search.
// Depends on uls_pkg.
`default_nettype none

module uls_step (
	input  uls_pkg::srch_state_t cur,
	input  uls_pkg::item_t       item,
	input  logic                 method,
	input  logic [30:0]          tolerance,
	input  logic [29:0]          probe_offset,
	output uls_pkg::srch_state_t nxt,
	output uls_pkg::result_t     res
);
	import uls_pkg::*;

	logic [TOL_W-1:0] tol_eff;
	logic [OFS_W-1:0] lim;
	logic [OFS_W-1:0] ofs;
	logic is_start;
	logic signed [COORD_W-1:0] vl_n;
	logic signed [COORD_W-1:0] vr_n;
	logic take_left;
	logic signed [COORD_W-1:0] nl;
	logic signed [COORD_W-1:0] nr;
	logic signed [COORD_W:0] w;
	logic signed [COORD_W:0] mid_sum;
	logic narrow;
	logic [2*COORD_W-1:0] prod;
	logic [COORD_W-1:0] step;
	logic signed [COORD_W-1:0] mid;
	logic signed [COORD_W-1:0] gold_l;
	logic signed [COORD_W-1:0] gold_r;
	logic signed [COORD_W-1:0] probe_l;
	logic signed [COORD_W-1:0] probe_r;

	always_comb begin
		tol_eff = (tolerance == '0) ? TOL_W'(1) : tolerance;
		lim = OFS_W'((tol_eff - TOL_W'(1)) >> 1);
		ofs = (probe_offset < lim) ? probe_offset : lim;
		is_start = (item.op == OP_START);

		vl_n = cur.value_left;
		vr_n = cur.value_right;
		if (!is_start && cur.phase == PH_LEFT_CMP) begin
			vl_n = item.value;
		end
		if (!is_start && cur.phase == PH_RIGHT_CMP) begin
			vr_n = item.value;
		end
		take_left = (vl_n < vr_n);

		nl = cur.left_end;
		nr = cur.right_end;
		if (is_start) begin
			nl = item.lower;
			nr = item.upper;
		end else if (take_left) begin
			nr = cur.inner_right;
		end else begin
			nl = cur.inner_left;
		end

		w = {nr[COORD_W-1], nr} - {nl[COORD_W-1], nl};
		narrow = (w <= $signed({2'b00, tol_eff}));
		mid_sum = {nl[COORD_W-1], nl} + {nr[COORD_W-1], nr};
		mid = mid_sum[COORD_W:1];
		prod = (2*COORD_W)'(w[COORD_W-1:0]) * (2*COORD_W)'(INV_PHI_Q32)
			+ 64'h0000_0000_8000_0000;
		step = prod[2*COORD_W-1:COORD_W];
		gold_l = nr - step;
		gold_r = nl + step;
		probe_l = mid - {2'b00, ofs};
		probe_r = mid + {2'b00, ofs};
	end

	always_comb begin
		nxt = cur;
		res = '0;
		if (is_start) begin
			nxt.left_end = nl;
			nxt.right_end = nr;
			nxt.reductions = '0;
			if (narrow) begin
				res.done_res = 1'b1;
				res.minimum_point = mid;
				nxt.phase = PH_IDLE;
			end else if (method == METHOD_GOLDEN) begin
				nxt.inner_left = gold_l;
				nxt.inner_right = gold_r;
				res.query_point = gold_l;
				res.query_valid = 1'b1;
				nxt.phase = PH_LEFT_NEXT;
			end else begin
				nxt.inner_left = probe_l;
				nxt.inner_right = probe_r;
				res.query_point = probe_l;
				res.query_valid = 1'b1;
				nxt.phase = PH_LEFT_NEXT;
			end
		end else begin
			case (cur.phase)
				PH_LEFT_NEXT: begin
					nxt.value_left = item.value;
					res.query_point = cur.inner_right;
					res.query_valid = 1'b1;
					nxt.phase = PH_RIGHT_CMP;
				end
				PH_LEFT_CMP, PH_RIGHT_CMP: begin
					nxt.value_left = vl_n;
					nxt.value_right = vr_n;
					if (cur.reductions != COUNT_MAX) begin
						nxt.reductions = cur.reductions + COUNT_W'(1);
					end
					nxt.left_end = nl;
					nxt.right_end = nr;
					if (method == METHOD_GOLDEN) begin
						if (take_left) begin
							nxt.inner_right = cur.inner_left;
							nxt.value_right = vl_n;
						end else begin
							nxt.inner_left = cur.inner_right;
							nxt.value_left = vr_n;
						end
					end
					if (narrow) begin
						res.done_res = 1'b1;
						res.minimum_point = mid;
						nxt.phase = PH_IDLE;
					end else if (method == METHOD_GOLDEN) begin
						res.query_valid = 1'b1;
						if (take_left) begin
							nxt.inner_left = gold_l;
							res.query_point = gold_l;
							nxt.phase = PH_LEFT_CMP;
						end else begin
							nxt.inner_right = gold_r;
							res.query_point = gold_r;
							nxt.phase = PH_RIGHT_CMP;
						end
					end else begin
						nxt.inner_left = probe_l;
						nxt.inner_right = probe_r;
						res.query_point = probe_l;
						res.query_valid = 1'b1;
						nxt.phase = PH_LEFT_NEXT;
					end
				end
				default: begin
					res.protocol_error = 1'b1;
				end
			endcase
		end
		res.iteration_count = nxt.reductions;
	end

endmodule

`default_nettype wire

[rtl/unimodal_line_search.sv]
// Each input goes to the input register, then to the output register or skid entry.
// Throughput: one item per cycle; the input register, the search state update and
// the golden-section multiply all complete in one stage, backed by a two-entry
// output buffer; the input stalls only when the input register and both entries are full.
// Reset (arst_n low, asynchronous): search idle, reduction count zero, method golden,
// tolerance 66, probe offset 16. Depends on uls_pkg and uls_step.
`default_nettype none

module unimodal_line_search (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // lower, upper, value
	input  logic [0:0]  s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // query_point, minimum_point, iteration_count
	output logic [2:0]  m_tuser   // query_valid, done_res, protocol_error
);
	import uls_pkg::*;

	logic method_q;
	logic [TOL_W-1:0] tol_q;
	logic [OFS_W-1:0] ofs_q;
	srch_state_t st_q;
	srch_state_t st_nxt;
	logic v_s1;
	item_t item_s1;
	result_t res_new;
	result_t res_q;
	logic res_v_q;
	result_t skid_q;
	logic skid_v_q;
	logic advance;
	logic s_accept;
	logic pop;

	assign advance = v_s1 && !skid_v_q;
	assign s_tready = !v_s1 || advance;
	assign s_accept = s_tvalid && s_tready;
	assign pop = res_v_q && m_tready;

	assign m_tvalid = res_v_q;
	assign m_tdata = {res_q.iteration_count, res_q.minimum_point, res_q.query_point};
	assign m_tuser = {res_q.protocol_error, res_q.done_res, res_q.query_valid};

	uls_step u_step (
		.cur          (st_q),
		.item         (item_s1),
		.method       (method_q),
		.tolerance    (tol_q),
		.probe_offset (ofs_q),
		.nxt          (st_nxt),
		.res          (res_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= METHOD_GOLDEN;
			tol_q <= TOL_W'(66);
			ofs_q <= OFS_W'(16);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_METHOD:       method_q <= cfg_data[0];
				CFG_TOLERANCE:    tol_q <= cfg_data;
				CFG_PROBE_OFFSET: ofs_q <= cfg_data[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_IDLE, default: '0};
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			item_s1 <= '{op: s_tuser[0], lower: s_tdata[31:0], upper: s_tdata[63:32],
				value: s_tdata[95:64]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else if (!advance) begin
				res_v_q <= 1'b0;
			end
		end else if (advance) begin
			if (!res_v_q) begin
				res_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_v_q) begin
			res_q <= skid_q;
		end else if (advance && (pop || !res_v_q)) begin
			res_q <= res_new;
		end
		if (advance && res_v_q && !pop) begin
			skid_q <= res_new;
		end
	end

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> res_v_q)
		else $error("Skid entry holds a result while the output register is empty.");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && skid_v_q))
		else $error("Input stalled while buffer space was free.");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.op == OP_VALUE) |=> st_q.reductions >= $past(st_q.reductions))
		else $error("Reduction count went down without a new search.");

	a_done_no_query: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[1]) |-> !m_tuser[0])
		else $error("A finished search also issued a query.");
`endif

endmodule

`default_nettype wire
